// ===== sv/ild_pkg.sv =====
// Shared constants, codes and types of the indexed list block.
`default_nettype none
package ild_pkg;

   // List capacity, one cell per entry
   localparam int DEPTH      = 64;

   // Fixed field widths
   localparam int CMD_W      = 2;
   localparam int POS_W      = 6;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 3;
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 7;

   // Derived internal widths
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Search tree: groups of eight match bits, then one pick among groups
   localparam int GROUP_SIZE = 8;
   localparam int SUB_W      = $clog2(GROUP_SIZE);
   localparam int GROUPS     = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GRP_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int FOUND_W    = GRP_W + SUB_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      logic                      insert_go;
      logic                      delete_go;
      logic                      find_go;
      logic [POS_W-1:0]          pos;
      logic [CNT_W-1:0]          count;
      logic signed [VALUE_W-1:0] value;
   } cell_bus_type;

   // Registered result of one group encoder
   typedef struct packed {
      logic             hit;
      logic [SUB_W-1:0] sub;
   } grp_type;

endpackage
`default_nettype wire

// ===== sv/ild_cell.sv =====
// One list cell: holds an entry, shifts with its neighbors, compares for find.
`default_nettype none
module ild_cell (
   input  wire logic                               clock,
   input  wire logic [ild_pkg::IDX_W-1:0]          cell_idx,
   input  wire ild_pkg::cell_bus_type              bus,
   input  wire logic signed [ild_pkg::VALUE_W-1:0] prev_data,
   input  wire logic signed [ild_pkg::VALUE_W-1:0] next_data,
   output logic signed [ild_pkg::VALUE_W-1:0]      data_ff,
   output logic                                    match_ff
);
   import ild_pkg::*;

   logic signed [VALUE_W-1:0] data_in;
   logic                      match_in;
   logic [CMP_W-1:0]          idx_ext;
   logic [CMP_W-1:0]          pos_ext;
   logic [CMP_W-1:0]          cnt_ext;

   assign idx_ext = CMP_W'(cell_idx);
   assign pos_ext = CMP_W'(bus.pos);
   assign cnt_ext = CMP_W'(bus.count);

   always_comb begin
      data_in = data_ff;
      if (bus.insert_go) begin
         if (idx_ext == pos_ext) begin
            data_in = bus.value;
         end else if (idx_ext > pos_ext) begin
            data_in = prev_data;
         end
      end else if (bus.delete_go) begin
         if (idx_ext >= pos_ext) begin
            data_in = next_data;
         end
      end
   end

   // Only held entries may match
   assign match_in = bus.find_go ? ((idx_ext < cnt_ext) && (data_ff == bus.value))
                                 : match_ff;

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

endmodule
`default_nettype wire

// ===== sv/ild_group_enc.sv =====
// Registered priority encoder over one group of eight cell match flags.
`default_nettype none
module ild_group_enc (
   input  wire logic                             clock,
   input  wire logic                             enable,
   input  wire logic [ild_pkg::GROUP_SIZE-1:0]   match,
   output ild_pkg::grp_type                      grp_ff
);
   import ild_pkg::*;

   grp_type grp_in;

   always_comb begin
      grp_in = grp_ff;
      if (enable) begin
         grp_in.hit = |match;
         grp_in.sub = '0;
         for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
            if (match[k]) begin
               grp_in.sub = SUB_W'(k);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

endmodule
`default_nettype wire

// ===== sv/indexed_list_insert_delete.sv =====
// Top level of the indexed list: controller, cell row and search tree.
//
// Usage
//   Command channel: drive req_cmd, req_position and req_value with start high;
//   the item is taken at a rising edge where start is high and busy is low.
//   Result channel: rsp_valid is high for exactly one cycle with rsp_status,
//   rsp_found_index and rsp_entry_count; the receiver cannot hold it off.
// Answers and throughput
//   Insert, delete, clear and a find on an empty list answer in the cycle after
//   the item is taken and busy stays low, so one such item a cycle.
//   A find on a non-empty list answers through registered steps: the cells
//   compare in parallel, group encoders pick the lowest hit in each group of
//   eight, then one pick among groups. busy is high in S_GROUP and S_SELECT.
// Reset
//   Synchronous reset empties the list (count zero) and drops any pending
//   result. Cell contents are not cleared; no command reads past the count.
// Stalls
//   None on the result side; results are never held back.
`default_nettype none
module indexed_list_insert_delete (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [ild_pkg::CMD_W-1:0]          req_cmd,
   input  wire logic [ild_pkg::POS_W-1:0]          req_position,
   input  wire logic signed [ild_pkg::VALUE_W-1:0] req_value,
   output logic                                    rsp_valid,
   output logic [ild_pkg::STATUS_W-1:0]            rsp_status,
   output logic [ild_pkg::INDEX_W-1:0]             rsp_found_index,
   output logic [ild_pkg::COUNT_W-1:0]             rsp_entry_count
);
   import ild_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_GROUP,
      S_SELECT
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   cell_bus_type          bus;
   logic                  accept;
   cmd_type               cmd;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic                  full;

   logic signed [VALUE_W-1:0] cell_data  [DEPTH];
   logic                      cell_match [DEPTH];
   logic [GROUPS*GROUP_SIZE-1:0] match_vec;
   grp_type                   grp [GROUPS];

   logic                  any_hit;
   logic [GRP_W-1:0]      sel_grp;
   logic [FOUND_W-1:0]    found_idx;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign cmd     = cmd_type'(req_cmd);
   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(count_ff);
   assign full    = (count_ff == CNT_W'(DEPTH));

   // Cell row: each cell sees its left and right neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_d;
      logic signed [VALUE_W-1:0] next_d;
      if (i == 0) begin : g_first
         assign prev_d = cell_data[i];
      end else begin : g_mid_prev
         assign prev_d = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_d = cell_data[i];
      end else begin : g_mid_next
         assign next_d = cell_data[i+1];
      end
      ild_cell u_cell (
         .clock     (clock),
         .cell_idx  (IDX_W'(i)),
         .bus       (bus),
         .prev_data (prev_d),
         .next_data (next_d),
         .data_ff   (cell_data[i]),
         .match_ff  (cell_match[i])
      );
   end

   // Pad the match flags out to whole groups
   always_comb begin
      match_vec = '0;
      for (int i = 0; i < DEPTH; i++) begin
         match_vec[i] = cell_match[i];
      end
   end

   for (genvar g = 0; g < GROUPS; g++) begin : g_grp
      ild_group_enc u_enc (
         .clock  (clock),
         .enable (state_ff == S_GROUP),
         .match  (match_vec[g*GROUP_SIZE +: GROUP_SIZE]),
         .grp_ff (grp[g])
      );
   end

   // Lowest group with a hit wins
   always_comb begin
      any_hit = 1'b0;
      sel_grp = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp[g].hit) begin
            any_hit = 1'b1;
            sel_grp = GRP_W'(g);
         end
      end
      found_idx = {sel_grp, grp[sel_grp].sub};
   end

   // Command decode: drive the cell bus, next count and the result
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;

      bus.insert_go = 1'b0;
      bus.delete_go = 1'b0;
      bus.find_go   = 1'b0;
      bus.pos       = req_position;
      bus.count     = count_ff;
      bus.value     = req_value;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_index_in  = '0;
               unique case (cmd)
                  CMD_INSERT: begin
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else if (pos_ext > cnt_ext) begin
                        rsp_status_in = ST_BADPOS;
                     end else begin
                        bus.insert_go = 1'b1;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     if (pos_ext >= cnt_ext) begin
                        rsp_status_in = ST_BADPOS;
                     end else begin
                        bus.delete_go = 1'b1;
                        count_in      = count_ff - 1'b1;
                     end
                  end
                  CMD_FIND: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        // Hold the result until the search tree settles
                        bus.find_go  = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = S_GROUP;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
               rsp_count_in = COUNT_W'(count_in);
            end
         end
         S_GROUP: begin
            state_in = S_SELECT;
         end
         S_SELECT: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = any_hit ? ST_OK : ST_NOTFOUND;
            rsp_index_in  = any_hit ? INDEX_W'(found_idx) : '0;
            rsp_count_in  = COUNT_W'(count_ff);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
`default_nettype wire

// ===== sv/ild_checker.sv =====
// Port-level assertions for the indexed list, bound to the top level.
`default_nettype none
module ild_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               start,
   input wire logic                               busy,
   input wire logic [ild_pkg::CMD_W-1:0]          req_cmd,
   input wire logic                               rsp_valid,
   input wire logic [ild_pkg::STATUS_W-1:0]       rsp_status,
   input wire logic [ild_pkg::INDEX_W-1:0]        rsp_found_index,
   input wire logic [ild_pkg::COUNT_W-1:0]        rsp_entry_count
);
   import ild_pkg::*;

   logic accept;
   assign accept = start && !busy;

   // Reset drops any pending result
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // Every command other than find answers in the next cycle
   a_fast_reply: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd != CMD_FIND)) |=> rsp_valid)
      else $error("missing one-cycle reply");

   // Clear always succeeds and empties the list
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_CLEAR)) |=>
         (rsp_valid && (rsp_status == ST_OK) && (rsp_entry_count == '0)))
      else $error("clear did not empty the list");

   // A failed command reports index zero
   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_found_index == '0))
      else $error("nonzero index on failed command");

   // Empty status only with an empty list
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_EMPTY)) |-> (rsp_entry_count == '0))
      else $error("empty status with entries held");

endmodule

bind indexed_list_insert_delete ild_checker u_ild_checker (.*);
`default_nettype wire

// ===== test/tb_indexed_list_insert_delete.sv =====
// Self-checking testbench for the indexed list: directed table, then random phases.
`timescale 1ns / 1ps
`default_nettype none
module tb_indexed_list_insert_delete;
   import ild_pkg::*;

   // Run length and safety limits
   localparam int RANDOM_ITEMS = 400;
   localparam int MAX_GAP      = 12;
   localparam int TAIL_CYCLES  = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int FILL_TAIL    = 4;
   localparam int MIX_LEN      = 40;
   localparam int PHASE_CAP    = 200;

   // Handy 32-bit patterns for the extremes of the value field
   localparam logic signed [VALUE_W-1:0] VAL_MIN  = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VAL_NEG1 = 32'shFFFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VAL_ZERO = 32'sh0000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MIX  = 32'sh5A5A_A5A5;

   typedef enum int {PH_FILL, PH_MIX, PH_DRAIN, PH_NOISE} phase_kind_type;

   // One answer the list should give, tagged with the cycle its item was taken
   typedef struct {
      status_type         status;
      logic [INDEX_W-1:0] found_index;
      logic [COUNT_W-1:0] entry_count;
      int unsigned        stamp;
   } list_answer_type;

   // One row of the directed table; fixed marks a row whose answer is typed in
   typedef struct packed {
      cmd_type                   cmd;
      logic [POS_W-1:0]          pos;
      logic signed [VALUE_W-1:0] val;
      logic                      fixed;
      status_type                status;
      logic [INDEX_W-1:0]        idx;
      logic [COUNT_W-1:0]        count;
   } script_row_type;

   localparam int SCRIPT_ROWS = 23;

   // Empty-list errors and extremes first, then a small list with duplicates,
   // searches that hit the first and last entry, deletes at both ends, clear.
   script_row_type script [SCRIPT_ROWS] = '{
      '{CMD_FIND,   6'd0,  VAL_ZERO, 1'b1, ST_EMPTY,    6'd0, 7'd0},
      '{CMD_DELETE, 6'd0,  VAL_ZERO, 1'b1, ST_BADPOS,   6'd0, 7'd0},
      '{CMD_INSERT, 6'd63, VAL_MAX,  1'b1, ST_BADPOS,   6'd0, 7'd0},
      '{CMD_INSERT, 6'd1,  VAL_MIN,  1'b1, ST_BADPOS,   6'd0, 7'd0},
      '{CMD_CLEAR,  6'd63, VAL_NEG1, 1'b1, ST_OK,       6'd0, 7'd0},
      '{CMD_INSERT, 6'd0,  VAL_MIN,  1'b1, ST_OK,       6'd0, 7'd1},
      '{CMD_INSERT, 6'd1,  VAL_MAX,  1'b1, ST_OK,       6'd0, 7'd2},
      '{CMD_INSERT, 6'd0,  VAL_NEG1, 1'b1, ST_OK,       6'd0, 7'd3},
      '{CMD_INSERT, 6'd4,  VAL_ZERO, 1'b1, ST_BADPOS,   6'd0, 7'd3},
      '{CMD_FIND,   6'd63, VAL_MAX,  1'b0, ST_OK,       6'd0, 7'd0},
      '{CMD_FIND,   6'd0,  VAL_MIN,  1'b0, ST_OK,       6'd0, 7'd0},
      '{CMD_FIND,   6'd0,  VAL_ZERO, 1'b1, ST_NOTFOUND, 6'd0, 7'd3},
      '{CMD_INSERT, 6'd1,  VAL_NEG1, 1'b0, ST_OK,       6'd0, 7'd0},
      '{CMD_FIND,   6'd0,  VAL_NEG1, 1'b0, ST_OK,       6'd0, 7'd0},
      '{CMD_DELETE, 6'd4,  VAL_ZERO, 1'b1, ST_BADPOS,   6'd0, 7'd4},
      '{CMD_DELETE, 6'd63, VAL_MAX,  1'b1, ST_BADPOS,   6'd0, 7'd4},
      '{CMD_DELETE, 6'd0,  VAL_ZERO, 1'b0, ST_OK,       6'd0, 7'd0},
      '{CMD_DELETE, 6'd2,  VAL_ZERO, 1'b0, ST_OK,       6'd0, 7'd0},
      '{CMD_FIND,   6'd0,  VAL_MAX,  1'b0, ST_OK,       6'd0, 7'd0},
      '{CMD_CLEAR,  6'd0,  VAL_ZERO, 1'b1, ST_OK,       6'd0, 7'd0},
      '{CMD_FIND,   6'd0,  VAL_NEG1, 1'b1, ST_EMPTY,    6'd0, 7'd0},
      '{CMD_INSERT, 6'd0,  VAL_MIX,  1'b1, ST_OK,       6'd0, 7'd1},
      '{CMD_INSERT, 6'd63, VAL_ZERO, 1'b1, ST_BADPOS,   6'd0, 7'd1}
   };

   // Block ports; every input holds a known value from time zero
   logic                      clock        = 1'b0;
   logic                      reset        = 1'b1;
   logic                      start        = 1'b0;
   logic                      busy;
   logic [CMD_W-1:0]          req_cmd      = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [VALUE_W-1:0] req_value    = '0;
   logic                      rsp_valid;
   logic [STATUS_W-1:0]       rsp_status;
   logic [INDEX_W-1:0]        rsp_found_index;
   logic [COUNT_W-1:0]        rsp_entry_count;

   // Shadow copy of the list contents and length
   logic signed [VALUE_W-1:0] list_cells [DEPTH];
   int unsigned               list_len = 0;

   // Answers waiting for the block, oldest first
   list_answer_type answers_pending [$];

   int unsigned cycle_count    = 0;
   int unsigned issued_count   = 0;
   int unsigned answered_count = 0;
   int unsigned error_count    = 0;

   indexed_list_insert_delete dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Apply one command to the shadow list and return the answer it must give
   function automatic list_answer_type run_command(cmd_type c, logic [POS_W-1:0] p,
                                                   logic signed [VALUE_W-1:0] v);
      list_answer_type ans;
      int unsigned     at;
      bit              hit;
      ans.status      = ST_OK;
      ans.found_index = '0;
      ans.stamp       = 0;
      at              = 32'(p);
      hit             = 1'b0;
      case (c)
         CMD_INSERT: begin
            if (list_len >= DEPTH) begin
               ans.status = ST_FULL;
            end else if (at > list_len) begin
               ans.status = ST_BADPOS;
            end else begin
               // open a gap at the position, then drop the value into it
               for (int unsigned j = list_len; j > at; j--) begin
                  list_cells[j] = list_cells[j-1];
               end
               list_cells[at] = v;
               list_len++;
            end
         end
         CMD_DELETE: begin
            if (at >= list_len) begin
               ans.status = ST_BADPOS;
            end else begin
               for (int unsigned j = at + 1; j < list_len; j++) begin
                  list_cells[j-1] = list_cells[j];
               end
               list_len--;
            end
         end
         CMD_FIND: begin
            if (list_len == 0) begin
               ans.status = ST_EMPTY;
            end else begin
               // lowest index wins; the last held entry counts too
               for (int unsigned j = 0; j < list_len; j++) begin
                  if (!hit && list_cells[j] == v) begin
                     hit             = 1'b1;
                     ans.found_index = INDEX_W'(j);
                  end
               end
               if (!hit) begin
                  ans.status = ST_NOTFOUND;
               end
            end
         end
         CMD_CLEAR: begin
            list_len = 0;
         end
      endcase
      ans.entry_count = COUNT_W'(list_len);
      return ans;
   endfunction

   // Pick an index below span, leaning on both ends; any index when span is zero
   function automatic logic [POS_W-1:0] pick_index(int unsigned span);
      int unsigned r;
      r = $urandom_range(0, 3);
      if (span == 0) begin
         return POS_W'($urandom);
      end else if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return POS_W'(span - 1);
      end
      return POS_W'($urandom_range(0, span - 1));
   endfunction

   // Values: small ones to force duplicates, extremes, and full random words
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 3);
      case (r)
         0: return VALUE_W'($urandom_range(0, 7));
         1: begin
            case ($urandom_range(0, 3))
               0:       return VAL_MIN;
               1:       return VAL_MAX;
               2:       return VAL_NEG1;
               default: return VAL_ZERO;
            endcase
         end
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // Search mostly for something held so finds hit at random depths
   function automatic logic signed [VALUE_W-1:0] pick_search();
      if (list_len != 0 && $urandom_range(0, 2) != 0) begin
         return list_cells[$urandom_range(0, list_len - 1)];
      end
      return pick_value();
   endfunction

   // Choose the next item for a random phase from the current list shape
   task automatic choose_item(input phase_kind_type ph, output cmd_type c,
                              output logic [POS_W-1:0] p,
                              output logic signed [VALUE_W-1:0] v);
      int unsigned r;
      int unsigned ins_span;
      r        = $urandom_range(0, 99);
      ins_span = (list_len < DEPTH) ? list_len + 1 : DEPTH;
      p        = POS_W'($urandom);
      v        = pick_value();
      case (ph)
         PH_FILL: begin
            if (r < 80) begin
               c = CMD_INSERT;
               p = pick_index(ins_span);
            end else if (r < 90) begin
               c = CMD_FIND;
               v = pick_search();
            end else begin
               c = CMD_DELETE;
               p = pick_index(list_len);
            end
         end
         PH_DRAIN: begin
            if (r < 75) begin
               c = CMD_DELETE;
               p = pick_index(list_len);
            end else if (r < 90) begin
               c = CMD_FIND;
               v = pick_search();
            end else begin
               c = CMD_INSERT;
               p = pick_index(ins_span);
            end
         end
         PH_MIX: begin
            if (r < 35) begin
               c = CMD_INSERT;
               if ($urandom_range(0, 4) != 0) p = pick_index(ins_span);
            end else if (r < 65) begin
               c = CMD_DELETE;
               if ($urandom_range(0, 4) != 0) p = pick_index(list_len);
            end else if (r < 95) begin
               c = CMD_FIND;
               v = pick_search();
            end else begin
               c = CMD_CLEAR;
            end
         end
         PH_NOISE: begin
            // raw fields: every bit of every field free
            c = cmd_type'(CMD_W'($urandom));
            v = VALUE_W'($urandom);
         end
      endcase
   endtask

   // Idle before an item: none in a burst, otherwise often none, up to MAX_GAP
   function automatic int draw_gap(bit burst);
      if (burst || $urandom_range(0, 2) == 0) begin
         return 0;
      end
      return $urandom_range(0, MAX_GAP);
   endfunction

   // Present one item, hold it until taken, and queue what it must answer.
   // While idle, start is low and the fields carry junk the block must ignore.
   task automatic issue_item(input cmd_type c, input logic [POS_W-1:0] p,
                             input logic signed [VALUE_W-1:0] v, input int gap,
                             input bit fixed, input list_answer_type fixed_ans);
      list_answer_type ans;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) begin
            req_cmd      <= CMD_W'($urandom);
            req_position <= POS_W'($urandom);
            req_value    <= VALUE_W'($urandom);
            @(posedge clock);
         end
      end
      start        <= 1'b1;
      req_cmd      <= c;
      req_position <= p;
      req_value    <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      // taken at this edge: advance the shadow list in the same step
      ans = run_command(c, p, v);
      if (fixed) begin
         ans.status      = fixed_ans.status;
         ans.found_index = fixed_ans.found_index;
         ans.entry_count = fixed_ans.entry_count;
      end
      ans.stamp = cycle_count;
      answers_pending.push_back(ans);
      issued_count++;
   endtask

   // Drop start and hold off until every queued answer has come back
   task automatic drain_answers();
      start <= 1'b0;
      do @(posedge clock); while (answered_count != issued_count);
   endtask

   task automatic report_field(input string field, input int unsigned want,
                               input int unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
   endtask

   // Compare each result with the oldest answer taken on an earlier edge
   always @(posedge clock) begin : check_answers
      list_answer_type want;
      if (!reset && rsp_valid) begin
         if (answers_pending.size() == 0 || answers_pending[0].stamp >= cycle_count) begin
            $display("%0t: result with nothing expected, actual status %0d index %0d count %0d",
                     $time, rsp_status, rsp_found_index, rsp_entry_count);
            error_count++;
         end else begin
            want = answers_pending.pop_front();
            if (rsp_status != want.status)
               report_field("status", want.status, rsp_status);
            if (rsp_found_index != want.found_index)
               report_field("found_index", want.found_index, rsp_found_index);
            if (rsp_entry_count != want.entry_count)
               report_field("entry_count", want.entry_count, rsp_entry_count);
            answered_count <= answered_count + 1;
         end
      end
   end

   // Hard stop if the block hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: cycle limit reached", $time);
      $display("tb_indexed_list_insert_delete: FAIL");
      $finish;
   end

   initial begin : stimulus
      list_answer_type fixed_ans;
      phase_kind_type  ph;
      cmd_type         c;
      logic [POS_W-1:0]          p;
      logic signed [VALUE_W-1:0] v;
      int  sent;
      int  tail;
      int  phase_no;
      bit  burst;
      phase_kind_type  order [5] = '{PH_FILL, PH_MIX, PH_DRAIN, PH_MIX, PH_NOISE};

      sent     = 0;
      phase_no = 0;
      fixed_ans.stamp = 0;

      // hold reset at the start, then release it once for good
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table: typed answers where obvious, shadow list elsewhere
      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         fixed_ans.status      = script[i].status;
         fixed_ans.found_index = script[i].idx;
         fixed_ans.entry_count = script[i].count;
         issue_item(script[i].cmd, script[i].pos, script[i].val,
                    draw_gap(i < 8), script[i].fixed, fixed_ans);
      end
      drain_answers();

      // random phases: fill to full and past it, mix, drain to empty and past it, mix, noise
      while (sent < RANDOM_ITEMS) begin
         ph    = order[phase_no % 5];
         burst = ($urandom_range(0, 3) == 0);
         tail  = FILL_TAIL;
         for (int k = 0; k < PHASE_CAP && sent < RANDOM_ITEMS; k++) begin
            choose_item(ph, c, p, v);
            issue_item(c, p, v, draw_gap(burst), 1'b0, fixed_ans);
            sent++;
            if ((ph == PH_FILL && list_len == DEPTH) || (ph == PH_DRAIN && list_len == 0)) begin
               if (tail == 0) break;
               tail--;
            end
            if ((ph == PH_MIX || ph == PH_NOISE) && k >= MIX_LEN - 1) break;
         end
         // after each drain, stop sending until the block has answered all
         if (ph == PH_DRAIN) drain_answers();
         phase_no++;
      end

      // wait for the last answers, then idle through the tail to catch strays
      drain_answers();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (answers_pending.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, answers_pending.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb_indexed_list_insert_delete: PASS");
      end else begin
         $display("tb_indexed_list_insert_delete: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
